[hdl/enfa_pkg.sv]
// ----------------------------------------------------------------------------
// enfa_pkg
// Shared types and constants for the epsilon-NFA string matcher.
// ----------------------------------------------------------------------------
package enfa_pkg;

    localparam int MAX_STATES      = 32;
    localparam int MAX_TRANSITIONS = 64;
    localparam int SYMBOL_BITS     = 8;
    localparam int CELLS_PER_GROUP = 8;
    localparam int NUM_GROUPS      = MAX_TRANSITIONS / CELLS_PER_GROUP;
    localparam int STATE_BITS      = $clog2(MAX_STATES);
    localparam int CELL_IDX_BITS   = $clog2(CELLS_PER_GROUP);
    localparam int GROUP_IDX_BITS  = $clog2(NUM_GROUPS);

    typedef logic [MAX_STATES-1:0] state_set_t;

    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_BEGIN = 2'd1,
        ACT_CHAR  = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HIT,
        ST_GROUP,
        ST_REDUCE,
        ST_HOLD
    } fsm_state_t;

    typedef struct packed {
        action_t     action;
        logic [5:0]  entry_index;
        logic        entry_valid;
        logic [4:0]  from_state;
        logic [4:0]  to_state;
        logic        epsilon_edge;
        logic [7:0]  symbol;
    } item_t;

    typedef struct packed {
        logic        accepted;
        logic [31:0] active_states;
    } result_t;

    typedef struct packed {
        logic                   valid;
        logic                   eps;
        logic [STATE_BITS-1:0]  src;
        logic [STATE_BITS-1:0]  dst;
        logic [SYMBOL_BITS-1:0] sym;
    } edge_t;

    typedef struct packed {
        logic                   eps_mode;
        logic [SYMBOL_BITS-1:0] sym;
        state_set_t             set;
    } pass_t;

endpackage

[hdl/epsilon_nfa_string_matcher_top.sv]
// ----------------------------------------------------------------------------
// epsilon_nfa_string_matcher_top
// Epsilon-NFA simulation over a row of transition-entry cells.
//
// Input channel (item_valid / item_stall / item): write a table entry, begin
// a string, or consume a character. Output channel (result_valid /
// result_stall / result): one transfer per begin or character item with the
// active set and the accepting flag. cfg_we / cfg_data set states_in_use.
// A table write gives no result. Each table pass runs through ST_HIT,
// ST_GROUP and ST_REDUCE: cells latch hits, groups latch chained hits, the
// top ORs the groups. Begin: closure passes run until a pass no longer
// grows the set. Character: one more pass, ahead of the closure passes.
// The next item is taken once the current one has finished; a result that
// waits in the output register does not block table writes, and a later
// result waits in the controller while the receiver stalls.
// Reset empties the table and the active set and sets states_in_use to 32.
// ----------------------------------------------------------------------------
module epsilon_nfa_string_matcher_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  enfa_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output enfa_pkg::result_t result,
    input  logic              cfg_we,
    input  logic [5:0]        cfg_data
);

    enfa_pkg::fsm_state_t   state_reg, state_next;
    enfa_pkg::state_set_t   set_reg, set_next;
    logic                   eps_mode_reg, eps_mode_next;
    logic [enfa_pkg::SYMBOL_BITS-1:0] sym_reg, sym_next;
    logic [5:0]             states_in_use_reg;
    logic                   result_valid_reg, result_valid_next;
    enfa_pkg::result_t      result_reg, result_next;

    enfa_pkg::pass_t        pass;
    enfa_pkg::edge_t        wr_edge;
    enfa_pkg::state_set_t   group_hits [enfa_pkg::NUM_GROUPS];
    enfa_pkg::state_set_t   all_hits;
    enfa_pkg::state_set_t   reduced;
    logic                   accept_item;
    logic                   table_wr;
    logic                   out_free;
    logic                   load_result;
    logic [enfa_pkg::STATE_BITS-1:0] accept_idx;

    assign accept_item = item_valid && !item_stall;
    assign table_wr    = accept_item && (item.action == enfa_pkg::ACT_WRITE);
    assign out_free    = !result_valid_reg || !result_stall;

    assign wr_edge.valid = item.entry_valid;
    assign wr_edge.eps   = item.epsilon_edge;
    assign wr_edge.src   = item.from_state[enfa_pkg::STATE_BITS-1:0];
    assign wr_edge.dst   = item.to_state[enfa_pkg::STATE_BITS-1:0];
    assign wr_edge.sym   = item.symbol[enfa_pkg::SYMBOL_BITS-1:0];

    assign pass.eps_mode = eps_mode_reg;
    assign pass.sym      = sym_reg;
    assign pass.set      = set_reg;

    for (genvar g = 0; g < enfa_pkg::NUM_GROUPS; g++)
    begin : g_group
        enfa_edge_group u_group (
            .clk     (clk),
            .rst_n   (rst_n),
            .wr_en   (table_wr && (item.entry_index[enfa_pkg::CELL_IDX_BITS +:
                                   enfa_pkg::GROUP_IDX_BITS] ==
                                   enfa_pkg::GROUP_IDX_BITS'(g))),
            .wr_cell (item.entry_index[enfa_pkg::CELL_IDX_BITS-1:0]),
            .wr_edge (wr_edge),
            .pass    (pass),
            .hits    (group_hits[g])
        );
    end

    always_comb
    begin
        all_hits = '0;
        for (int g = 0; g < enfa_pkg::NUM_GROUPS; g++)
        begin
            all_hits = all_hits | group_hits[g];
        end
        reduced = eps_mode_reg ? (set_reg | all_hits) : all_hits;
    end

    always_comb
    begin
        if (states_in_use_reg == 6'd0)
        begin
            accept_idx = '0;
        end
        else if (states_in_use_reg > 6'(enfa_pkg::MAX_STATES))
        begin
            accept_idx = enfa_pkg::STATE_BITS'(enfa_pkg::MAX_STATES - 1);
        end
        else
        begin
            accept_idx = enfa_pkg::STATE_BITS'(states_in_use_reg - 6'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= enfa_pkg::ST_IDLE;
            set_reg           <= '0;
            eps_mode_reg      <= 1'b0;
            states_in_use_reg <= 6'd32;
            result_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            set_reg          <= set_next;
            eps_mode_reg     <= eps_mode_next;
            result_valid_reg <= result_valid_next;
            if (cfg_we)
            begin
                states_in_use_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sym_reg    <= sym_next;
        result_reg <= result_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        set_next      = set_reg;
        eps_mode_next = eps_mode_reg;
        sym_next      = sym_reg;
        load_result   = 1'b0;
        item_stall    = (state_reg != enfa_pkg::ST_IDLE);

        unique case (state_reg)
            enfa_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    unique case (item.action)
                        enfa_pkg::ACT_BEGIN:
                        begin
                            set_next      = enfa_pkg::state_set_t'(1);
                            eps_mode_next = 1'b1;
                            state_next    = enfa_pkg::ST_HIT;
                        end
                        enfa_pkg::ACT_CHAR:
                        begin
                            sym_next      = item.symbol[enfa_pkg::SYMBOL_BITS-1:0];
                            eps_mode_next = 1'b0;
                            state_next    = enfa_pkg::ST_HIT;
                        end
                        default:
                        begin
                            state_next = enfa_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            enfa_pkg::ST_HIT:
            begin
                state_next = enfa_pkg::ST_GROUP;
            end
            enfa_pkg::ST_GROUP:
            begin
                state_next = enfa_pkg::ST_REDUCE;
            end
            enfa_pkg::ST_REDUCE:
            begin
                if (!eps_mode_reg || (reduced != set_reg))
                begin
                    set_next      = reduced;
                    eps_mode_next = 1'b1;
                    state_next    = enfa_pkg::ST_HIT;
                end
                else if (out_free)
                begin
                    load_result = 1'b1;
                    state_next  = enfa_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = enfa_pkg::ST_HOLD;
                end
            end
            enfa_pkg::ST_HOLD:
            begin
                if (out_free)
                begin
                    load_result = 1'b1;
                    state_next  = enfa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = enfa_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        result_next       = result_reg;
        result_valid_next = result_valid_reg && result_stall;
        if (load_result)
        begin
            result_next.accepted      = set_reg[accept_idx];
            result_next.active_states = 32'(set_reg);
            result_valid_next         = 1'b1;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

[hdl/enfa_edge_cell.sv]
// ----------------------------------------------------------------------------
// enfa_edge_cell
// Holds one transition entry; fires its target bit into the chain accumulator.
// ----------------------------------------------------------------------------
module enfa_edge_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  enfa_pkg::edge_t     wr_edge,
    input  enfa_pkg::pass_t     pass,
    input  enfa_pkg::state_set_t acc_in,
    output enfa_pkg::state_set_t acc_out
);

    enfa_pkg::edge_t      edge_reg;
    logic                 valid_reg;
    enfa_pkg::state_set_t hit_reg;
    enfa_pkg::state_set_t hit_next;
    logic                 fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            valid_reg <= wr_edge.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            edge_reg <= wr_edge;
        end
        hit_reg <= hit_next;
    end

    always_comb
    begin
        fire = valid_reg && pass.set[edge_reg.src] &&
               (pass.eps_mode ? edge_reg.eps
                              : (!edge_reg.eps && (edge_reg.sym == pass.sym)));
        hit_next = '0;
        hit_next[edge_reg.dst] = fire;
    end

    assign acc_out = acc_in | hit_reg;

endmodule

[hdl/enfa_edge_group.sv]
// ----------------------------------------------------------------------------
// enfa_edge_group
// A short chain of edge cells; registers the chained target set at its end.
// ----------------------------------------------------------------------------
module enfa_edge_group (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  wr_en,
    input  logic [enfa_pkg::CELL_IDX_BITS-1:0]    wr_cell,
    input  enfa_pkg::edge_t                       wr_edge,
    input  enfa_pkg::pass_t                       pass,
    output enfa_pkg::state_set_t                  hits
);

    enfa_pkg::state_set_t chain [enfa_pkg::CELLS_PER_GROUP+1];
    enfa_pkg::state_set_t hits_reg;

    assign chain[0] = '0;

    for (genvar i = 0; i < enfa_pkg::CELLS_PER_GROUP; i++)
    begin : g_cell
        enfa_edge_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .wr_en   (wr_en && (wr_cell == enfa_pkg::CELL_IDX_BITS'(i))),
            .wr_edge (wr_edge),
            .pass    (pass),
            .acc_in  (chain[i]),
            .acc_out (chain[i+1])
        );
    end

    always_ff @(posedge clk)
    begin
        hits_reg <= chain[enfa_pkg::CELLS_PER_GROUP];
    end

    assign hits = hits_reg;

endmodule
